// ----- rtl/fbs_pkg.sv -----
// package: table geometry, codes and controller/datapath interface types
`default_nettype none
package fbs_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;

	localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
	localparam int FIELD_W = 16;
	localparam int EIDX_W  = 4;
	localparam int MODE_W  = 2;
	localparam int BCNT_W  = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 4'd1;

	typedef struct packed {
		logic             wr_en;
		logic             start;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             eval;
		logic             finish;
	} cmd_t;

	typedef struct packed {
		logic             stop;
		logic             out_busy;
		logic [CNT_W-1:0] limit;
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/fbs_item_if.sv -----
// interface: input item channel
`default_nettype none
interface fbs_item_if import fbs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [EIDX_W-1:0]  entry_index;
	logic [FIELD_W-1:0] entry_size;
	logic [FIELD_W-1:0] request_size;

	modport source (output valid, op, entry_index, entry_size, request_size, input ready);
	modport sink   (input valid, op, entry_index, entry_size, request_size, output ready);
endinterface
`default_nettype wire

// ----- rtl/fbs_result_if.sv -----
// interface: result channel
`default_nettype none
interface fbs_result_if import fbs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               found;
	logic [EIDX_W-1:0]  chosen_index;
	logic [FIELD_W-1:0] chosen_size;
	logic [FIELD_W-1:0] leftover;

	modport source (output valid, found, chosen_index, chosen_size, leftover, input ready);
	modport sink   (input valid, found, chosen_index, chosen_size, leftover, output ready);
endinterface
`default_nettype wire

// ----- rtl/fbs_cfg_if.sv -----
// interface: configuration write channel
`default_nettype none
interface fbs_cfg_if import fbs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/fbs_dp.sv -----
// datapath: size table, scan compare, pick registers, config and result register
`default_nettype none
module fbs_dp import fbs_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cmd_t          cmd,
	output sts_t               sts,
	input  wire logic [EIDX_W-1:0]  entry_index,
	input  wire logic [FIELD_W-1:0] entry_size,
	input  wire logic [FIELD_W-1:0] request_size,
	fbs_cfg_if.sink            cfg,
	fbs_result_if.source       result
);

	logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];
	logic [SIZE_BITS-1:0] rd_size_s1;
	logic [IDX_W-1:0]     ev_idx_s1;

	logic [MODE_W-1:0]    fit_mode_q;
	logic [BCNT_W-1:0]    block_count_q;

	logic [SIZE_BITS-1:0] req_q;
	logic                 hit_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] pick_size_q;

	logic                 out_valid_q;
	logic                 found_q;
	logic [EIDX_W-1:0]    chosen_index_q;
	logic [FIELD_W-1:0]   chosen_size_q;
	logic [FIELD_W-1:0]   leftover_q;

	logic                 fits;
	logic                 take;

	// config registers; the user must write them only while idle, the block itself does not enforce it
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= MODE_FIRST;
			block_count_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FIT_MODE:    fit_mode_q    <= cfg.data[MODE_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= cfg.data[BCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate the entry count to the table depth
	assign sts.limit = (32'(block_count_q) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
	                                                     : CNT_W'(block_count_q);

	// size table, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en && (32'(entry_index) < MAX_BLOCKS)) begin
			mem[IDX_W'(entry_index)] <= SIZE_BITS'(entry_size);
		end
		if (cmd.rd_en) begin
			rd_size_s1 <= mem[cmd.rd_addr];
			ev_idx_s1  <= cmd.rd_addr;
		end
	end

	assign fits = (rd_size_s1 >= req_q);
	assign take = fits && (!hit_q
	              || ((fit_mode_q == MODE_BEST)  && (rd_size_s1 < pick_size_q))
	              || ((fit_mode_q == MODE_WORST) && (rd_size_s1 > pick_size_q)));

	// first fit ends at the first entry that is large enough
	assign sts.stop = cmd.eval && fits && !hit_q
	                  && (fit_mode_q != MODE_BEST) && (fit_mode_q != MODE_WORST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.start) begin
			hit_q <= 1'b0;
		end else if (cmd.eval && take) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= SIZE_BITS'(request_size);
		end
		if (cmd.eval && take) begin
			pick_q      <= ev_idx_s1;
			pick_size_q <= rd_size_s1;
		end
	end

	// result register
	assign sts.out_busy = out_valid_q && !result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_q        <= hit_q;
			chosen_index_q <= hit_q ? EIDX_W'(pick_q) : '0;
			chosen_size_q  <= hit_q ? FIELD_W'(pick_size_q) : '0;
			leftover_q     <= hit_q ? FIELD_W'(pick_size_q - req_q) : '0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.found        = found_q;
	assign result.chosen_index = chosen_index_q;
	assign result.chosen_size  = chosen_size_q;
	assign result.leftover     = leftover_q;

endmodule
`default_nettype wire

// ----- rtl/fbs_ctrl.sv -----
// controller: accepts items and sequences the table scan
`default_nettype none
module fbs_ctrl import fbs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	input  wire logic item_op,
	output logic      item_ready,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             accept;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		cmd.rd_addr = cnt_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && (item_op == OP_WRITE)) begin
					cmd.wr_en = 1'b1;
				end else if (accept) begin
					cmd.start = 1'b1;
					cnt_d     = '0;
					state_d   = (sts.limit == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				// read entry cnt while the entry before it is compared
				cmd.rd_en = 1'b1;
				cmd.eval  = (cnt_q != '0);
				cnt_d     = cnt_q + 1'b1;
				if (cmd.eval && sts.stop) begin
					state_d = ST_DONE;
				end else if (cnt_d == sts.limit) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.eval = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (32'(cmd.rd_addr) < 32'(sts.limit)))
		else $error("table read beyond block count");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.out_busy)
		else $error("result loaded over a waiting result");

	a_empty_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start && (sts.limit == '0)) |=> (state_q == ST_DONE))
		else $error("empty scan did not go straight to result");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> ($past(state_d) == ST_IDLE || state_q == ST_IDLE))
		else $error("table written outside idle");

endmodule
`default_nettype wire

// ----- rtl/fit_block_selector.sv -----
// top level: free-block fit selector (first, best or worst fit)
//
// channels: item (sink) carries write beats (op 0: entry_index, entry_size)
// and query beats (op 1: request_size); result (source) carries one beat per
// query with found, chosen_index, chosen_size and leftover; cfg (sink) writes
// register 0 fit_mode or register 1 block_count, always ready
// a write beat is taken while idle, where item ready stays high, so write
// beats can follow back to back; a query scans the table one entry per cycle
// through the single read port of the size table, with the compare in the
// cycle after the read; with L = min(block_count, 16), a query runs SCAN over
// L entries, DRAIN for the last compare and DONE to load the result register
// and return to idle (DONE at once when L is 0); first fit ends the scan at its hit
// reset clears the config registers and control, the table stays undefined
// until written; entries scanned by a query must have been written
// when the receiver stalls the finished result holds in the output register,
// write beats are still taken, one more query is scanned and its result waits
// for the slot with item ready low until the held beat leaves
`default_nettype none
module fit_block_selector import fbs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fbs_item_if.sink     item,
	fbs_result_if.source result,
	fbs_cfg_if.sink      cfg
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: item handshake and scan stepping
	fbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_op    (item.op),
		.item_ready (item.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// table, compare and pick registers, result register
	fbs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.entry_index  (item.entry_index),
		.entry_size   (item.entry_size),
		.request_size (item.request_size),
		.cfg          (cfg),
		.result       (result)
	);

endmodule
`default_nettype wire
